>>> sv/jcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jcw_pkg: shared types, constants and microcode for the joint chain block
// Word widths, controller/datapath command and status structs, the MAC
// microcode for one composition step and the fixed-point helpers.
// ----------------------------------------------------------------------------
package jcw_pkg;

  localparam int IDX_W  = 6;
  localparam int PAR_W  = 7;
  localparam int CNT_W  = 7;
  localparam int ROT_W  = 16;
  localparam int POS_W  = 32;
  localparam int T_W    = 36;
  localparam int M_W    = 34;
  localparam int A_W    = 34;
  localparam int B_W    = 36;
  localparam int ACC_W  = 64;
  localparam int ROOT_W = 32;
  localparam int NUM_W  = 50;
  localparam int DEN_W  = 33;
  localparam int QUO_W  = 16;
  localparam int STEP_W = 6;
  localparam int COMP_W = 2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic signed [ROT_W-1:0] ONE_Q14   = 16'sd16384;
  localparam logic signed [PAR_W-1:0] NO_PARENT = -7'sd1;
  localparam logic [STEP_W-1:0]       MAC_LAST  = 6'd36;
  localparam logic [COMP_W-1:0]       LAST_COMP = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_WALK_CHK, S_WALK_LD, S_POP, S_FETCH, S_MAC,
    S_SQ_CHK, S_SQ_RUN, S_DIV_GO, S_DIV_RUN, S_NEXT
  } state_t;

  typedef enum logic [2:0] {A_CW, A_CX, A_CY, A_CZ, A_MW, A_MX, A_MY, A_MZ} asel_t;

  typedef enum logic [3:0] {
    B_VX, B_VY, B_VZ, B_TX, B_TY, B_TZ, B_LW, B_LX, B_LY, B_LZ,
    B_MW, B_MX, B_MY, B_MZ
  } bsel_t;

  typedef enum logic [3:0] {
    D_NONE, D_TX, D_TY, D_TZ, D_PX, D_PY, D_PZ, D_MW, D_MX, D_MY, D_MZ, D_SUM
  } dst_t;

  typedef struct packed {
    logic  valid;
    asel_t a;
    bsel_t b;
    logic  neg;
    logic  first;
    dst_t  dst;
  } uop_t;

  typedef struct packed {
    logic              wr_item;
    logic              q_init;
    logic              push;
    logic              load_parent;
    logic              pop;
    logic              fetch;
    logic              mac_en;
    logic [STEP_W-1:0] step;
    logic              sq_start;
    logic              set_ident;
    logic              div_start;
    logic [COMP_W-1:0] comp;
    logic              res_ok;
    logic              res_fail;
  } ctl_cmd_t;

  typedef struct packed {
    logic walk_end;
    logic walk_bad;
    logic len_zero;
    logic sum_zero;
    logic sq_done;
    logic div_done;
  } ctl_sts_t;

  localparam uop_t UOP_NOP = '{1'b0, A_CW, B_VX, 1'b0, 1'b0, D_NONE};

  function automatic uop_t uop(input asel_t a, input bsel_t b, input logic neg,
                               input logic first, input dst_t dst);
    return '{1'b1, a, b, neg, first, dst};
  endfunction

  // t = 2(u x v), p += v + w t + u x t, m = c * l, then sum of squares of m
  function automatic uop_t ucode(input logic [STEP_W-1:0] step);
    uop_t u;
    u = UOP_NOP;
    unique case (step)
      6'd0:  u = uop(A_CY, B_VZ, 1'b0, 1'b1, D_NONE);
      6'd1:  u = uop(A_CZ, B_VY, 1'b1, 1'b0, D_TX);
      6'd2:  u = uop(A_CZ, B_VX, 1'b0, 1'b1, D_NONE);
      6'd3:  u = uop(A_CX, B_VZ, 1'b1, 1'b0, D_TY);
      6'd4:  u = uop(A_CX, B_VY, 1'b0, 1'b1, D_NONE);
      6'd5:  u = uop(A_CY, B_VX, 1'b1, 1'b0, D_TZ);
      6'd6:  u = uop(A_CW, B_TX, 1'b0, 1'b1, D_NONE);
      6'd7:  u = uop(A_CZ, B_TY, 1'b1, 1'b0, D_NONE);
      6'd8:  u = uop(A_CY, B_TZ, 1'b0, 1'b0, D_PX);
      6'd9:  u = uop(A_CW, B_TY, 1'b0, 1'b1, D_NONE);
      6'd10: u = uop(A_CZ, B_TX, 1'b0, 1'b0, D_NONE);
      6'd11: u = uop(A_CX, B_TZ, 1'b1, 1'b0, D_PY);
      6'd12: u = uop(A_CW, B_TZ, 1'b0, 1'b1, D_NONE);
      6'd13: u = uop(A_CX, B_TY, 1'b0, 1'b0, D_NONE);
      6'd14: u = uop(A_CY, B_TX, 1'b1, 1'b0, D_PZ);
      6'd15: u = uop(A_CW, B_LW, 1'b0, 1'b1, D_NONE);
      6'd16: u = uop(A_CX, B_LX, 1'b1, 1'b0, D_NONE);
      6'd17: u = uop(A_CY, B_LY, 1'b1, 1'b0, D_NONE);
      6'd18: u = uop(A_CZ, B_LZ, 1'b1, 1'b0, D_MW);
      6'd19: u = uop(A_CW, B_LX, 1'b0, 1'b1, D_NONE);
      6'd20: u = uop(A_CX, B_LW, 1'b0, 1'b0, D_NONE);
      6'd21: u = uop(A_CY, B_LZ, 1'b0, 1'b0, D_NONE);
      6'd22: u = uop(A_CZ, B_LY, 1'b1, 1'b0, D_MX);
      6'd23: u = uop(A_CW, B_LY, 1'b0, 1'b1, D_NONE);
      6'd24: u = uop(A_CY, B_LW, 1'b0, 1'b0, D_NONE);
      6'd25: u = uop(A_CZ, B_LX, 1'b0, 1'b0, D_NONE);
      6'd26: u = uop(A_CX, B_LZ, 1'b1, 1'b0, D_MY);
      6'd27: u = uop(A_CW, B_LZ, 1'b0, 1'b1, D_NONE);
      6'd28: u = uop(A_CZ, B_LW, 1'b0, 1'b0, D_NONE);
      6'd29: u = uop(A_CX, B_LY, 1'b0, 1'b0, D_NONE);
      6'd30: u = uop(A_CY, B_LX, 1'b1, 1'b0, D_MZ);
      6'd31: u = uop(A_MW, B_MW, 1'b0, 1'b1, D_NONE);
      6'd32: u = uop(A_MX, B_MX, 1'b0, 1'b0, D_NONE);
      6'd33: u = uop(A_MY, B_MY, 1'b0, 1'b0, D_NONE);
      6'd34: u = uop(A_MZ, B_MZ, 1'b0, 1'b0, D_SUM);
      default: u = UOP_NOP;
    endcase
    return u;
  endfunction

  // shift right by 14, round half away from zero
  function automatic logic signed [ACC_W-1:0] rnd14(input logic signed [ACC_W-1:0] a);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] r;
    mag = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    r   = (mag + ACC_W'(8192)) >> 14;
    return a[ACC_W-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [ACC_W-1:0] a);
    logic signed [POS_W-1:0] r;
    if (a > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (a < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = a[POS_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/jcw_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jcw_isqrt: bit-pair integer square root
// Floor square root of a 64-bit word, one result bit per cycle.
// ----------------------------------------------------------------------------
module jcw_isqrt import jcw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [ACC_W-1:0]  value,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);

  logic             run;
  logic [ACC_W-1:0] s;
  logic [ACC_W-1:0] r;
  logic [ACC_W-1:0] bitm;
  logic [ACC_W-1:0] trial;
  logic             ge;

  assign trial = r + bitm;
  assign ge    = s >= trial;
  assign root  = r[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && bitm == ACC_W'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s    <= value;
      r    <= '0;
      bitm <= ACC_W'(1) << (ACC_W - 2);
    end else if (run) begin
      if (ge) begin
        s <= s - trial;
        r <= (r >> 1) + bitm;
      end else begin
        r <= r >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

endmodule
`default_nettype wire

>>> sv/jcw_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jcw_div: restoring divider
// Unsigned quotient of a known-small ratio, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jcw_div import jcw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  output logic                   done,
  output logic [QUO_W-1:0]       quo
);

  localparam int CB = $clog2(QUO_W);

  logic             run;
  logic [CB-1:0]    cnt;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;
  logic             ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CB'(QUO_W - 1);
      end else if (run) begin
        cnt <= cnt - CB'(1);
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= NUM_W'(den) << (QUO_W - 1);
      quo <= '0;
    end else if (run) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quo <= {quo[QUO_W-2:0], ge};
      dsh <= dsh >> 1;
    end
  end

endmodule
`default_nettype wire

>>> sv/jcw_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jcw_dp: joint chain datapath
// Skeleton tables, chain stack, MAC pipeline, square root and divider,
// and the result registers.
// ----------------------------------------------------------------------------
module jcw_dp import jcw_pkg::*; #(
  parameter int MAX_JOINTS = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire ctl_cmd_t                cmd,
  output ctl_sts_t                     sts,
  input  wire logic                    cfg_we,
  input  wire logic [CNT_W-1:0]        cfg_data,
  input  wire logic [IDX_W-1:0]        joint_index,
  input  wire logic signed [PAR_W-1:0] parent_index,
  input  wire logic signed [ROT_W-1:0] rot_w,
  input  wire logic signed [ROT_W-1:0] rot_x,
  input  wire logic signed [ROT_W-1:0] rot_y,
  input  wire logic signed [ROT_W-1:0] rot_z,
  input  wire logic signed [POS_W-1:0] trans_x,
  input  wire logic signed [POS_W-1:0] trans_y,
  input  wire logic signed [POS_W-1:0] trans_z,
  output logic                         done,
  output logic                         ok,
  output logic signed [ROT_W-1:0]      orient_w,
  output logic signed [ROT_W-1:0]      orient_x,
  output logic signed [ROT_W-1:0]      orient_y,
  output logic signed [ROT_W-1:0]      orient_z,
  output logic signed [POS_W-1:0]      world_x,
  output logic signed [POS_W-1:0]      world_y,
  output logic signed [POS_W-1:0]      world_z
);

  localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int LW = $clog2(MAX_JOINTS + 1);
  localparam int CW = (LW > CNT_W) ? LW : CNT_W;
  localparam logic [CW-1:0] MAXJ = CW'(MAX_JOINTS);

  logic [CNT_W-1:0]         joint_count;
  logic [CW-1:0]            count;
  logic [CW-1:0]            len;
  logic [CW-1:0]            len_m1;
  logic signed [PAR_W-1:0]  walk;
  logic [AW-1:0]            waddr;
  logic [AW-1:0]            paddr;
  logic                     wr_in_range;

  logic [PAR_W-1:0]         parent_mem [MAX_JOINTS];
  logic [4*ROT_W-1:0]       rot_mem    [MAX_JOINTS];
  logic [POS_W-1:0]         offx_mem   [MAX_JOINTS];
  logic [POS_W-1:0]         offy_mem   [MAX_JOINTS];
  logic [POS_W-1:0]         offz_mem   [MAX_JOINTS];
  logic [AW-1:0]            stack_mem  [MAX_JOINTS];

  logic [PAR_W-1:0]         par_q;
  logic [4*ROT_W-1:0]       rot_q;
  logic [POS_W-1:0]         offx_q;
  logic [POS_W-1:0]         offy_q;
  logic [POS_W-1:0]         offz_q;
  logic [AW-1:0]            stk_q;

  logic signed [POS_W-1:0]  v [3];
  logic signed [ROT_W-1:0]  l [4];
  logic signed [ROT_W-1:0]  c [4];
  logic signed [POS_W-1:0]  p [3];
  logic signed [T_W-1:0]    t [3];
  logic signed [M_W-1:0]    m [4];
  logic [ACC_W-1:0]         sumsq;

  uop_t                     u;
  uop_t                     p1;
  uop_t                     p2;
  logic signed [A_W-1:0]    a_op;
  logic signed [B_W-1:0]    b_op;
  logic signed [A_W+B_W-1:0] full;
  logic signed [ACC_W-1:0]  prod;
  logic signed [ACC_W-1:0]  acc;

  logic                     sq_done;
  logic [ROOT_W-1:0]        root;
  logic                     dv_done;
  logic [QUO_W-1:0]         quo;
  logic signed [M_W-1:0]    m_sel;
  logic [M_W-1:0]           mag;
  logic [NUM_W-1:0]         num;
  logic [DEN_W-1:0]         den;
  logic signed [ROT_W-1:0]  c_new;

  assign count       = (CW'(joint_count) > MAXJ) ? MAXJ : CW'(joint_count);
  assign len_m1      = len - CW'(1);
  assign waddr       = AW'(joint_index);
  assign paddr       = AW'(walk[IDX_W-1:0]);
  assign wr_in_range = CW'(joint_index) < MAXJ;

  assign v[0] = $signed(offx_q);
  assign v[1] = $signed(offy_q);
  assign v[2] = $signed(offz_q);
  assign l[0] = $signed(rot_q[ROT_W-1:0]);
  assign l[1] = $signed(rot_q[2*ROT_W-1:ROT_W]);
  assign l[2] = $signed(rot_q[3*ROT_W-1:2*ROT_W]);
  assign l[3] = $signed(rot_q[4*ROT_W-1:3*ROT_W]);

  assign sts.walk_end = walk == NO_PARENT;
  assign sts.walk_bad = walk[PAR_W-1] || (CW'(walk[IDX_W-1:0]) >= count) || (len == count);
  assign sts.len_zero = len == '0;
  assign sts.sum_zero = sumsq == '0;
  assign sts.sq_done  = sq_done;
  assign sts.div_done = dv_done;

  // tables and chain stack
  always_ff @(posedge clk) begin
    if (cmd.wr_item && wr_in_range) begin
      parent_mem[waddr] <= parent_index;
      rot_mem[waddr]    <= {rot_z, rot_y, rot_x, rot_w};
      offx_mem[waddr]   <= trans_x;
      offy_mem[waddr]   <= trans_y;
      offz_mem[waddr]   <= trans_z;
    end
    if (cmd.push) begin
      stack_mem[len[AW-1:0]] <= paddr;
      par_q                  <= parent_mem[paddr];
    end
    if (cmd.pop) begin
      stk_q <= stack_mem[len_m1[AW-1:0]];
    end
    if (cmd.fetch) begin
      rot_q  <= rot_mem[stk_q];
      offx_q <= offx_mem[stk_q];
      offy_q <= offy_mem[stk_q];
      offz_q <= offz_mem[stk_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      joint_count <= '0;
    end else if (cfg_we) begin
      joint_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      walk <= $signed({1'b0, joint_index});
      len  <= '0;
    end else if (cmd.push) begin
      len <= len + CW'(1);
    end else if (cmd.load_parent) begin
      walk <= par_q;
    end else if (cmd.pop) begin
      len <= len_m1;
    end
  end

  // MAC: operand select, product register, accumulate, write back
  assign u = ucode(cmd.step);

  always_comb begin
    unique case (u.a)
      A_CW:    a_op = A_W'(c[0]);
      A_CX:    a_op = A_W'(c[1]);
      A_CY:    a_op = A_W'(c[2]);
      A_CZ:    a_op = A_W'(c[3]);
      A_MW:    a_op = A_W'(m[0]);
      A_MX:    a_op = A_W'(m[1]);
      A_MY:    a_op = A_W'(m[2]);
      A_MZ:    a_op = A_W'(m[3]);
      default: a_op = '0;
    endcase
  end

  always_comb begin
    unique case (u.b)
      B_VX:    b_op = B_W'(v[0]);
      B_VY:    b_op = B_W'(v[1]);
      B_VZ:    b_op = B_W'(v[2]);
      B_TX:    b_op = t[0];
      B_TY:    b_op = t[1];
      B_TZ:    b_op = t[2];
      B_LW:    b_op = B_W'(l[0]);
      B_LX:    b_op = B_W'(l[1]);
      B_LY:    b_op = B_W'(l[2]);
      B_LZ:    b_op = B_W'(l[3]);
      B_MW:    b_op = B_W'(m[0]);
      B_MX:    b_op = B_W'(m[1]);
      B_MY:    b_op = B_W'(m[2]);
      B_MZ:    b_op = B_W'(m[3]);
      default: b_op = '0;
    endcase
  end

  assign full = a_op * b_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= UOP_NOP;
      p2 <= UOP_NOP;
    end else begin
      p1 <= cmd.mac_en ? u : UOP_NOP;
      p2 <= p1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= full[ACC_W-1:0];
    if (p1.valid) begin
      acc <= (p1.first ? '0 : acc) + (p1.neg ? -prod : prod);
    end
  end

  // divider operands for the selected product component
  assign m_sel = m[cmd.comp];
  assign mag   = m_sel[M_W-1] ? M_W'(-m_sel) : M_W'(m_sel);
  assign num   = NUM_W'({mag, 15'd0}) + NUM_W'(root);
  assign den   = {root, 1'b0};
  assign c_new = m_sel[M_W-1] ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (cmd.q_init || cmd.set_ident) begin
      c[0] <= ONE_Q14;
      c[1] <= '0;
      c[2] <= '0;
      c[3] <= '0;
    end else if (dv_done) begin
      c[cmd.comp] <= c_new;
    end
    if (cmd.q_init) begin
      p[0] <= '0;
      p[1] <= '0;
      p[2] <= '0;
    end else if (p2.valid) begin
      unique case (p2.dst)
        D_TX:    t[0] <= T_W'(rnd14(acc <<< 1));
        D_TY:    t[1] <= T_W'(rnd14(acc <<< 1));
        D_TZ:    t[2] <= T_W'(rnd14(acc <<< 1));
        D_PX:    p[0] <= sat32(ACC_W'(p[0]) + ACC_W'(v[0]) + rnd14(acc));
        D_PY:    p[1] <= sat32(ACC_W'(p[1]) + ACC_W'(v[1]) + rnd14(acc));
        D_PZ:    p[2] <= sat32(ACC_W'(p[2]) + ACC_W'(v[2]) + rnd14(acc));
        D_MW:    m[0] <= M_W'(acc);
        D_MX:    m[1] <= M_W'(acc);
        D_MY:    m[2] <= M_W'(acc);
        D_MZ:    m[3] <= M_W'(acc);
        D_SUM:   sumsq <= acc;
        default: ;
      endcase
    end
  end

  jcw_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sq_start),
    .value (sumsq),
    .done  (sq_done),
    .root  (root)
  );

  jcw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .done  (dv_done),
    .quo   (quo)
  );

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.wr_item || cmd.res_ok || cmd.res_fail;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ok) begin
      ok       <= 1'b1;
      orient_w <= c[0];
      orient_x <= c[1];
      orient_y <= c[2];
      orient_z <= c[3];
      world_x  <= p[0];
      world_y  <= p[1];
      world_z  <= p[2];
    end else if (cmd.wr_item || cmd.res_fail) begin
      ok       <= cmd.wr_item && wr_in_range;
      orient_w <= '0;
      orient_x <= '0;
      orient_y <= '0;
      orient_z <= '0;
      world_x  <= '0;
      world_y  <= '0;
      world_z  <= '0;
    end
  end

endmodule
`default_nettype wire

>>> sv/jcw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jcw_ctrl: joint chain sequencer
// Walks the parent chain, then steps each joint through MAC microcode and,
// unless the sum of squares is zero, square root and four divides.
// ----------------------------------------------------------------------------
module jcw_ctrl import jcw_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire logic     item_cmd,
  input  wire ctl_sts_t sts,
  output ctl_cmd_t      cmd,
  output logic          busy
);

  state_t              state;
  state_t              state_next;
  logic [STEP_W-1:0]   step;
  logic [COMP_W-1:0]   comp;

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      comp  <= '0;
    end else begin
      state <= state_next;
      step  <= (state == S_MAC) ? step + STEP_W'(1) : '0;
      if (state == S_SQ_CHK) begin
        comp <= '0;
      end else if (state == S_DIV_RUN && sts.div_done) begin
        comp <= comp + COMP_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (accept && item_cmd == CMD_QUERY) state_next = S_WALK_CHK;
      S_WALK_CHK: begin
        if (sts.walk_end) begin
          state_next = S_POP;
        end else if (sts.walk_bad) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_WALK_LD;
        end
      end
      S_WALK_LD:  state_next = S_WALK_CHK;
      S_POP:      state_next = S_FETCH;
      S_FETCH:    state_next = S_MAC;
      S_MAC:      if (step == MAC_LAST) state_next = S_SQ_CHK;
      S_SQ_CHK:   state_next = sts.sum_zero ? S_NEXT : S_SQ_RUN;
      S_SQ_RUN:   if (sts.sq_done) state_next = S_DIV_GO;
      S_DIV_GO:   state_next = S_DIV_RUN;
      S_DIV_RUN:  if (sts.div_done) state_next = (comp == LAST_COMP) ? S_NEXT : S_DIV_GO;
      S_NEXT:     state_next = sts.len_zero ? S_IDLE : S_POP;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.step = step;
    cmd.comp = comp;
    unique case (state)
      S_IDLE: begin
        cmd.wr_item = accept && item_cmd == CMD_WRITE;
        cmd.q_init  = accept && item_cmd == CMD_QUERY;
      end
      S_WALK_CHK: begin
        cmd.push     = !sts.walk_end && !sts.walk_bad;
        cmd.res_fail = !sts.walk_end && sts.walk_bad;
      end
      S_WALK_LD:  cmd.load_parent = 1'b1;
      S_POP:      cmd.pop = 1'b1;
      S_FETCH:    cmd.fetch = 1'b1;
      S_MAC:      cmd.mac_en = 1'b1;
      S_SQ_CHK: begin
        cmd.set_ident = sts.sum_zero;
        cmd.sq_start  = !sts.sum_zero;
      end
      S_SQ_RUN:   ;
      S_DIV_GO:   cmd.div_start = 1'b1;
      S_DIV_RUN:  ;
      S_NEXT:     cmd.res_ok = sts.len_zero;
      default:    ;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/joint_chain_world_transform.sv
`default_nettype none
// ----------------------------------------------------------------------------
// joint_chain_world_transform: forward kinematics over a joint table
// Write: result in the cycle after start; a new word may start every cycle.
// Query: walks the parent chain, then composes each joint with the shared
//   MAC (37 steps), the bit-pair square root (32 steps) and the shared
//   divider (4 x 16 steps).
// busy is high for the whole query; done pulses once per word, no stall.
// Reset clears control and joint_count; the tables hold nothing until written.
// ----------------------------------------------------------------------------
module joint_chain_world_transform import jcw_pkg::*; #(
  parameter int MAX_JOINTS = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    cmd,
  input  wire logic [IDX_W-1:0]        joint_index,
  input  wire logic signed [PAR_W-1:0] parent_index,
  input  wire logic signed [ROT_W-1:0] rot_w,
  input  wire logic signed [ROT_W-1:0] rot_x,
  input  wire logic signed [ROT_W-1:0] rot_y,
  input  wire logic signed [ROT_W-1:0] rot_z,
  input  wire logic signed [POS_W-1:0] trans_x,
  input  wire logic signed [POS_W-1:0] trans_y,
  input  wire logic signed [POS_W-1:0] trans_z,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CNT_W-1:0]        cfg_data,
  output logic                         done,
  output logic                         ok,
  output logic signed [ROT_W-1:0]      orient_w,
  output logic signed [ROT_W-1:0]      orient_x,
  output logic signed [ROT_W-1:0]      orient_y,
  output logic signed [ROT_W-1:0]      orient_z,
  output logic signed [POS_W-1:0]      world_x,
  output logic signed [POS_W-1:0]      world_y,
  output logic signed [POS_W-1:0]      world_z
);

  logic     accept;
  ctl_cmd_t ctl_cmd;
  ctl_sts_t ctl_sts;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  jcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item_cmd (cmd),
    .sts      (ctl_sts),
    .cmd      (ctl_cmd),
    .busy     (busy)
  );

  jcw_dp #(
    .MAX_JOINTS (MAX_JOINTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (ctl_cmd),
    .sts          (ctl_sts),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .joint_index  (joint_index),
    .parent_index (parent_index),
    .rot_w        (rot_w),
    .rot_x        (rot_x),
    .rot_y        (rot_y),
    .rot_z        (rot_z),
    .trans_x      (trans_x),
    .trans_y      (trans_y),
    .trans_z      (trans_z),
    .done         (done),
    .ok           (ok),
    .orient_w     (orient_w),
    .orient_x     (orient_x),
    .orient_y     (orient_y),
    .orient_z     (orient_z),
    .world_x      (world_x),
    .world_y      (world_y),
    .world_z      (world_z)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result word while busy");

  a_write_one: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_WRITE |=> done)
    else $error("write word gave no result");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_QUERY |=> busy && !done)
    else $error("query not taken up");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && !ok |-> orient_w == '0 && orient_x == '0 && orient_y == '0 &&
                    orient_z == '0 && world_x == '0 && world_y == '0 && world_z == '0)
    else $error("refused word carries data");

endmodule
`default_nettype wire

>>> verif/joint_chain_world_transform_tb.sv
// ----------------------------------------------------------------------------
// joint_chain_world_transform_tb: self-checking bench for the joint chain block
// Writes skeleton entries and queries world transforms under several joint
// counts. A scoreboard class predicts each result in fixed point and checks
// every done word in order. Start and config are driven at the rising edge.
// ----------------------------------------------------------------------------
module joint_chain_world_transform_tb;
  import jcw_pkg::*;

  typedef struct {
    logic                    cmd;
    logic [IDX_W-1:0]        jidx;
    logic signed [PAR_W-1:0] par;
    logic signed [ROT_W-1:0] rot [4];
    logic signed [POS_W-1:0] trn [3];
  } joint_word_t;

  typedef struct {
    logic                    ok;
    logic signed [ROT_W-1:0] orient [4];
    logic signed [POS_W-1:0] pos [3];
  } pose_t;

  class pose_scoreboard;
    logic signed [PAR_W-1:0] par_tab [64];
    logic signed [ROT_W-1:0] rot_tab [64][4];
    logic signed [POS_W-1:0] off_tab [64][3];
    bit                      written [64];
    int                      eff_count;
    pose_t                   pending [$];
    int                      errors;
    int                      good_queries;
    int                      refused_queries;
    int                      writes;

    function new();
      eff_count = 0;
      errors = 0;
      good_queries = 0;
      refused_queries = 0;
      writes = 0;
      foreach (written[i]) written[i] = 0;
    endfunction

    function void set_count(int v);
      eff_count = (v > 64) ? 64 : v;
    endfunction

    static function longint rnd_q14(longint a);
      if (a >= 0) return (a + 8192) >>> 14;
      return -((-a + 8192) >>> 14);
    endfunction

    static function longint clamp32(longint a);
      if (a > 64'sd2147483647) return 64'sd2147483647;
      if (a < -64'sd2147483648) return -64'sd2147483648;
      return a;
    endfunction

    static function logic [63:0] int_sqrt(logic [63:0] s);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s = s - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    static function longint unit_div(longint p, logic [63:0] n);
      logic [63:0] mag;
      logic [63:0] q;
      mag = (p < 0) ? 64'(-p) : 64'(p);
      q = (mag * 64'd32768 + n) / (64'd2 * n);
      return (p < 0) ? -longint'(q) : longint'(q);
    endfunction

    // true if a query of this joint would touch an entry never written
    function bit touches_unwritten(int idx);
      int walk;
      int len;
      walk = idx;
      len = 0;
      while (walk != -1) begin
        if (walk < 0 || walk >= eff_count || len == eff_count) return 0;
        if (!written[walk]) return 1;
        len++;
        walk = par_tab[walk];
      end
      return 0;
    endfunction

    function pose_t world_pose(int idx);
      pose_t  r;
      int     walk;
      int     chain [$];
      longint c [4];
      longint l [4];
      longint m [4];
      longint p [3];
      longint v [3];
      longint t [3];
      logic [63:0] sum;
      logic [63:0] n;
      int     s;
      r.ok = 0;
      foreach (r.orient[i]) r.orient[i] = 0;
      foreach (r.pos[i]) r.pos[i] = 0;
      walk = idx;
      while (walk != -1) begin
        if (walk < 0 || walk >= eff_count || chain.size() == eff_count) return r;
        chain = {chain, walk};
        walk = par_tab[walk];
      end
      c = '{16384, 0, 0, 0};
      p = '{0, 0, 0};
      for (int k = chain.size() - 1; k >= 0; k--) begin
        s = chain[k];
        for (int i = 0; i < 3; i++) v[i] = longint'(off_tab[s][i]);
        t[0] = rnd_q14(2 * (c[2] * v[2] - c[3] * v[1]));
        t[1] = rnd_q14(2 * (c[3] * v[0] - c[1] * v[2]));
        t[2] = rnd_q14(2 * (c[1] * v[1] - c[2] * v[0]));
        p[0] = clamp32(p[0] + v[0] + rnd_q14(c[0] * t[0] + c[2] * t[2] - c[3] * t[1]));
        p[1] = clamp32(p[1] + v[1] + rnd_q14(c[0] * t[1] + c[3] * t[0] - c[1] * t[2]));
        p[2] = clamp32(p[2] + v[2] + rnd_q14(c[0] * t[2] + c[1] * t[1] - c[2] * t[0]));
        for (int i = 0; i < 4; i++) l[i] = longint'(rot_tab[s][i]);
        m[0] = c[0] * l[0] - c[1] * l[1] - c[2] * l[2] - c[3] * l[3];
        m[1] = c[0] * l[1] + l[0] * c[1] + c[2] * l[3] - c[3] * l[2];
        m[2] = c[0] * l[2] + l[0] * c[2] + c[3] * l[1] - c[1] * l[3];
        m[3] = c[0] * l[3] + l[0] * c[3] + c[1] * l[2] - c[2] * l[1];
        sum = 64'(m[0] * m[0]) + 64'(m[1] * m[1]) + 64'(m[2] * m[2]) + 64'(m[3] * m[3]);
        if (sum == 0) begin
          c = '{16384, 0, 0, 0};
        end else begin
          n = int_sqrt(sum);
          for (int i = 0; i < 4; i++) c[i] = unit_div(m[i], n);
        end
      end
      r.ok = 1;
      for (int i = 0; i < 4; i++) r.orient[i] = c[i][15:0];
      for (int i = 0; i < 3; i++) r.pos[i] = p[i][31:0];
      return r;
    endfunction

    function void note_word(joint_word_t w);
      pose_t r;
      if (w.cmd == CMD_WRITE) begin
        par_tab[w.jidx] = w.par;
        for (int i = 0; i < 4; i++) rot_tab[w.jidx][i] = w.rot[i];
        for (int i = 0; i < 3; i++) off_tab[w.jidx][i] = w.trn[i];
        written[w.jidx] = 1;
        r.ok = 1;
        foreach (r.orient[i]) r.orient[i] = 0;
        foreach (r.pos[i]) r.pos[i] = 0;
        writes++;
      end else begin
        r = world_pose(w.jidx);
        if (r.ok) good_queries++;
        else refused_queries++;
      end
      pending = {pending, r};
    endfunction

    function void check_result(pose_t got);
      pose_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word, ok=%0d", $time, got.ok);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.ok !== e.ok) begin
        $display("%0t: ok expected %0d actual %0d", $time, e.ok, got.ok);
        errors++;
      end
      for (int i = 0; i < 4; i++)
        if (got.orient[i] !== e.orient[i]) begin
          $display("%0t: orient[%0d] expected %0d actual %0d", $time, i, e.orient[i],
                   got.orient[i]);
          errors++;
        end
      for (int i = 0; i < 3; i++)
        if (got.pos[i] !== e.pos[i]) begin
          $display("%0t: world[%0d] expected %0d actual %0d", $time, i, e.pos[i],
                   got.pos[i]);
          errors++;
        end
    endfunction
  endclass

  logic                    clk = 0;
  logic                    rst = 1;
  logic                    start = 0;
  logic                    busy;
  logic                    cmd = 0;
  logic [IDX_W-1:0]        joint_index = 0;
  logic signed [PAR_W-1:0] parent_index = 0;
  logic signed [ROT_W-1:0] rot_w = 0, rot_x = 0, rot_y = 0, rot_z = 0;
  logic signed [POS_W-1:0] trans_x = 0, trans_y = 0, trans_z = 0;
  logic                    cfg_valid = 0;
  logic                    cfg_ready;
  logic [CNT_W-1:0]        cfg_data = 0;
  logic                    done;
  logic                    ok;
  logic signed [ROT_W-1:0] orient_w, orient_x, orient_y, orient_z;
  logic signed [POS_W-1:0] world_x, world_y, world_z;

  pose_scoreboard sb = new();
  int             word_no = 0;
  int             idle_cycles = 0;

  always #6 clk = ~clk;

  joint_chain_world_transform dut (
    .clk, .rst, .start, .busy, .cmd, .joint_index, .parent_index,
    .rot_w, .rot_x, .rot_y, .rot_z, .trans_x, .trans_y, .trans_z,
    .cfg_valid, .cfg_ready, .cfg_data, .done, .ok,
    .orient_w, .orient_x, .orient_y, .orient_z, .world_x, .world_y, .world_z
  );

  always @(posedge clk) begin
    pose_t got;
    if (!rst && done) begin
      got.ok = ok;
      got.orient = '{orient_w, orient_x, orient_y, orient_z};
      got.pos = '{world_x, world_y, world_z};
      sb.check_result(got);
    end
  end

  // watchdog: cycles with no word moved on any channel
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 200000) begin
      $display("watchdog expired at %0t", $time);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(joint_word_t w);
    if (!(word_no >= 300 && word_no < 500) && $urandom_range(99) < 6) begin
      start <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start <= 1;
    cmd <= w.cmd;
    joint_index <= w.jidx;
    parent_index <= w.par;
    rot_w <= w.rot[0];
    rot_x <= w.rot[1];
    rot_y <= w.rot[2];
    rot_z <= w.rot[3];
    trans_x <= w.trn[0];
    trans_y <= w.trn[1];
    trans_z <= w.trn[2];
    do @(posedge clk); while (busy);
    sb.note_word(w);
    word_no++;
  endtask

  task automatic write_count(int v);
    start <= 0;
    do @(posedge clk); while (sb.pending.size() != 0 || busy);
    repeat (8) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= CNT_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_count(v);
  endtask

  function automatic joint_word_t make_write(int j, int p, int rw, int rx, int ry, int rz,
                                             int tx, int ty, int tz);
    joint_word_t w;
    w.cmd = CMD_WRITE;
    w.jidx = IDX_W'(j);
    w.par = PAR_W'(p);
    w.rot = '{ROT_W'(rw), ROT_W'(rx), ROT_W'(ry), ROT_W'(rz)};
    w.trn = '{tx, ty, tz};
    return w;
  endfunction

  function automatic joint_word_t make_query(int j);
    joint_word_t w;
    w = make_write(j, 0, 0, 0, 0, 0, 0, 0, 0);
    w.cmd = CMD_QUERY;
    return w;
  endfunction

  function automatic logic signed [ROT_W-1:0] rand_rot();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 10) return 16'sh7fff;
    if (r < 15) return 16'sh8000;
    if (r < 60) return ROT_W'($urandom_range(0, 32768) - 16384);
    return ROT_W'($urandom);
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pos();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 32'sh7fffffff;
    if (r < 10) return 32'sh80000000;
    if (r < 60) return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    return $urandom;
  endfunction

  task automatic random_words(int n);
    joint_word_t w;
    int          j;
    int          r;
    for (int k = 0; k < n; k++) begin
      j = $urandom_range(63);
      w = make_query(j);
      if ($urandom_range(99) < 45 || sb.touches_unwritten(j)) begin
        r = $urandom_range(99);
        w.cmd = CMD_WRITE;
        if (r < 65 && j > 0) w.par = PAR_W'(j - $urandom_range(1, (j < 6) ? j : 6));
        else if (r < 80) w.par = NO_PARENT;
        else w.par = PAR_W'($urandom);
        w.rot = '{rand_rot(), rand_rot(), rand_rot(), rand_rot()};
        w.trn = '{rand_pos(), rand_pos(), rand_pos()};
        w.cmd = CMD_WRITE;
      end
      send_word(w);
    end
  endtask

  initial begin
    int settings [8] = '{64, 127, 1, 0, 0, 0, 0, 64};
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: extremes, zero rotation, cycle, bad parents, saturation
    write_count(8);
    send_word(make_write(0, -1, 16384, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000));
    send_word(make_write(1, 0, 32767, -32768, 32767, -32768,
                         32'h7fffffff, 32'h80000000, 32'h7fffffff));
    send_word(make_write(2, 1, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000));
    send_word(make_write(3, 2, -32768, 0, 0, 0, 1, -1, 0));
    send_word(make_write(4, 5, 11585, 11585, 0, 0, 65536, 0, 0));
    send_word(make_write(5, 4, 11585, 0, 11585, 0, 0, 65536, 0));
    send_word(make_write(6, -64, 16384, 0, 0, 0, 0, 0, 0));
    send_word(make_write(7, 63, 16384, 0, 0, 0, 0, 0, 0));
    send_word(make_write(63, 62, -1, 1, -1, 1, -1, -1, -1));
    for (int j = 0; j < 8; j++) send_word(make_query(j));
    send_word(make_query(63));
    send_word(make_query(8));
    write_count(0);
    send_word(make_query(0));

    for (int ph = 0; ph < 8; ph++) begin
      write_count(ph >= 3 && ph <= 6 ? $urandom_range(2, 63) : settings[ph]);
      random_words(123);
    end

    start <= 0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (200) @(posedge clk);
    $display("covered %0d writes, %0d valid and %0d refused queries over 10 joint counts",
             sb.writes, sb.good_queries, sb.refused_queries);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
